// File: rtl/jsu_pkg.sv
`timescale 1ns / 1ps
// Shared types, character codes and helpers for the JSON string unescape core.
// No dependencies; used by json_string_unescape_core.
package jsu_pkg;

	// Decoder mode. The unused encoding behaves like MODE_OPEN.
	typedef enum logic [2:0] {
		MODE_OPEN = 3'd0,
		MODE_BODY = 3'd1,
		MODE_ESC  = 3'd2,
		MODE_HEX0 = 3'd3,
		MODE_HEX1 = 3'd4,
		MODE_HEX2 = 3'd5,
		MODE_HEX3 = 3'd6
	} mode_t;

	// One result word: decoded byte plus end-of-string mark
	typedef struct packed {
		logic [7:0] data;
		logic       is_end;
	} res_t;

	// Result queue depth (power of two, at least 2)
	localparam int RES_DEPTH = 4;
	localparam int RES_AW    = $clog2(RES_DEPTH);
	localparam int RES_CW    = $clog2(RES_DEPTH + 1);

	// Character codes
	localparam logic [7:0] CH_NUL   = 8'h00;
	localparam logic [7:0] CH_QUOTE = 8'h22;
	localparam logic [7:0] CH_BSL   = 8'h5C;
	localparam logic [7:0] CH_B     = 8'h62;
	localparam logic [7:0] CH_F     = 8'h66;
	localparam logic [7:0] CH_N     = 8'h6E;
	localparam logic [7:0] CH_R     = 8'h72;
	localparam logic [7:0] CH_T     = 8'h74;
	localparam logic [7:0] CH_U     = 8'h75;
	localparam logic [7:0] CH_SLASH = 8'h2F;

	// Control bytes produced by escapes
	localparam logic [7:0] BY_BS = 8'h08;
	localparam logic [7:0] BY_FF = 8'h0C;
	localparam logic [7:0] BY_LF = 8'h0A;
	localparam logic [7:0] BY_CR = 8'h0D;
	localparam logic [7:0] BY_HT = 8'h09;

	// Hex digit value; anything that is not a hex digit counts as zero
	function automatic logic [3:0] hex_value(input logic [7:0] c);
		logic [3:0] v;
		v = 4'd0;
		if (c >= 8'h30 && c <= 8'h39) begin
			v = c[3:0];
		end else if ((c >= 8'h41 && c <= 8'h46) || (c >= 8'h61 && c <= 8'h66)) begin
			v = c[3:0] + 4'd9;
		end
		return v;
	endfunction

endpackage

// File: rtl/json_string_unescape_core.sv
`timescale 1ns / 1ps
// JSON string unescape core: input register, combinational decode, small result queue.
// Throughput: one input word per cycle unless in_stall is high; a \u escape writes
// two result words at once, which leave one per cycle unless out_stall is high;
// input stalls while a word is held and more than two words wait in the queue.
// Reset (arst_n low, asynchronous): queue empty, decoder awaits opening char.
// Depends on jsu_pkg.
module json_string_unescape_core (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [7:0] ch,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [7:0] out_byte,
	output logic       is_end
);

	localparam int DEPTH = jsu_pkg::RES_DEPTH;
	localparam int AW    = jsu_pkg::RES_AW;
	localparam int CW    = jsu_pkg::RES_CW;

	// Input register
	logic        valid_s1;
	logic [7:0]  ch_s1;

	// Decoder state
	jsu_pkg::mode_t mode_q, mode_d;
	logic [11:0] acc_q, acc_d;

	// Result queue
	jsu_pkg::res_t res_q [DEPTH];
	logic [AW-1:0] wp_q, rp_q;
	logic [CW-1:0] cnt_q;

	// Decode outputs
	jsu_pkg::res_t res0, res1;
	logic [1:0]    n_res;
	logic [3:0]    hv;
	logic          proc, pop, load;

	// Decode one word only when at least two queue slots are free
	assign proc     = valid_s1 && (cnt_q <= CW'(DEPTH - 2));
	assign load     = !valid_s1 || proc;
	assign in_stall = !load;
	assign pop      = out_valid && !out_stall;

	assign out_valid = (cnt_q != '0);
	assign out_byte  = res_q[rp_q].data;
	assign is_end    = res_q[rp_q].is_end;

	assign hv = jsu_pkg::hex_value(ch_s1);

	// Decode the held character against the current mode
	always_comb begin
		mode_d = mode_q;
		acc_d  = acc_q;
		n_res  = 2'd0;
		res0   = '{data: ch_s1, is_end: 1'b0};
		res1   = '{data: acc_q[11:4], is_end: 1'b0};
		case (mode_q)
			jsu_pkg::MODE_BODY: begin
				if (ch_s1 == jsu_pkg::CH_NUL || ch_s1 == jsu_pkg::CH_QUOTE) begin
					n_res  = 2'd1;
					res0   = '{data: 8'h00, is_end: 1'b1};
					mode_d = jsu_pkg::MODE_OPEN;
					acc_d  = '0;
				end else if (ch_s1 == jsu_pkg::CH_BSL) begin
					mode_d = jsu_pkg::MODE_ESC;
				end else begin
					n_res = 2'd1;
				end
			end
			jsu_pkg::MODE_ESC: begin
				if (ch_s1 == jsu_pkg::CH_NUL) begin
					n_res  = 2'd1;
					res0   = '{data: 8'h00, is_end: 1'b1};
					mode_d = jsu_pkg::MODE_OPEN;
					acc_d  = '0;
				end else begin
					mode_d = jsu_pkg::MODE_BODY;
					n_res  = 2'd1;
					case (ch_s1)
						jsu_pkg::CH_B: res0.data = jsu_pkg::BY_BS;
						jsu_pkg::CH_F: res0.data = jsu_pkg::BY_FF;
						jsu_pkg::CH_N: res0.data = jsu_pkg::BY_LF;
						jsu_pkg::CH_R: res0.data = jsu_pkg::BY_CR;
						jsu_pkg::CH_T: res0.data = jsu_pkg::BY_HT;
						jsu_pkg::CH_U: begin
							n_res  = 2'd0;
							mode_d = jsu_pkg::MODE_HEX0;
							acc_d  = '0;
						end
						default: res0.data = ch_s1;
					endcase
				end
			end
			jsu_pkg::MODE_HEX0, jsu_pkg::MODE_HEX1, jsu_pkg::MODE_HEX2: begin
				if (ch_s1 == jsu_pkg::CH_NUL) begin
					n_res  = 2'd1;
					res0   = '{data: 8'h00, is_end: 1'b1};
					mode_d = jsu_pkg::MODE_OPEN;
					acc_d  = '0;
				end else begin
					acc_d = {acc_q[7:0], hv};
					case (mode_q)
						jsu_pkg::MODE_HEX0: mode_d = jsu_pkg::MODE_HEX1;
						jsu_pkg::MODE_HEX1: mode_d = jsu_pkg::MODE_HEX2;
						default:            mode_d = jsu_pkg::MODE_HEX3;
					endcase
				end
			end
			jsu_pkg::MODE_HEX3: begin
				if (ch_s1 == jsu_pkg::CH_NUL) begin
					n_res  = 2'd1;
					res0   = '{data: 8'h00, is_end: 1'b1};
					mode_d = jsu_pkg::MODE_OPEN;
					acc_d  = '0;
				end else begin
					n_res  = 2'd2;
					res0   = '{data: {acc_q[3:0], hv}, is_end: 1'b0};
					mode_d = jsu_pkg::MODE_BODY;
					acc_d  = '0;
				end
			end
			default: begin
				// Drop the opening character
				mode_d = jsu_pkg::MODE_BODY;
				acc_d  = '0;
			end
		endcase
	end

	// Advance the input register and decoder state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			mode_q   <= jsu_pkg::MODE_OPEN;
			acc_q    <= '0;
		end else begin
			if (load) begin
				valid_s1 <= in_valid;
			end
			if (proc) begin
				mode_q <= mode_d;
				acc_q  <= acc_d;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load && in_valid) begin
			ch_s1 <= ch;
		end
	end

	// Write results into the queue
	always_ff @(posedge clk) begin
		if (proc && n_res != 2'd0) begin
			res_q[wp_q] <= res0;
		end
		if (proc && n_res == 2'd2) begin
			res_q[wp_q + AW'(1)] <= res1;
		end
	end

	// Track queue pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (proc) begin
				wp_q <= wp_q + AW'(n_res);
			end
			if (pop) begin
				rp_q <= rp_q + AW'(1);
			end
			cnt_q <= cnt_q + CW'(proc ? n_res : 2'd0) - CW'(pop);
		end
	end

	// Queue never overfills
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CW'(DEPTH))
		else $error("result queue over depth");

	// An end result returns the decoder to awaiting the opening char
	a_end_mode: assert property (@(posedge clk) disable iff (!arst_n)
		(proc && n_res != 2'd0 && res0.is_end) |=> (mode_q == jsu_pkg::MODE_OPEN))
		else $error("end result without mode return");

	// A \u escape always starts from a clear accumulator
	a_hex_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(mode_q == jsu_pkg::MODE_HEX0) |-> (acc_q == 12'd0))
		else $error("accumulator not clear at hex start");

	// A held word waiting on the queue keeps the decoder state
	a_hold_state: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !proc) |=> ($stable(mode_q) && $stable(acc_q) && valid_s1))
		else $error("decoder state moved while word held");

	// Neither result of a byte pair carries the end mark
	a_pair_plain: assert property (@(posedge clk) disable iff (!arst_n)
		(proc && n_res == 2'd2) |-> (!res0.is_end && !res1.is_end))
		else $error("end mark inside a byte pair");

endmodule
